// ===== design/m2alu_pkg.sv =====
// shared types, constants and helpers of the 2x2 matrix unit
package m2alu_pkg;

	localparam int ElemWidth = 16;
	localparam int FracBits = 8;
	localparam int ProdWidth = 2 * ElemWidth;
	localparam int SumWidth = ProdWidth + 1;
	localparam int DetWidth = ProdWidth + 1;
	localparam int NumWidth = ElemWidth + 1 + 2 * FracBits;
	localparam int QuoWidth = NumWidth;

	typedef enum logic [2:0] {
		CMD_ADD = 3'd0,
		CMD_SUB = 3'd1,
		CMD_MUL = 3'd2,
		CMD_SCALE = 3'd3,
		CMD_DET = 3'd4,
		CMD_TRANSPOSE = 3'd5,
		CMD_INVERSE = 3'd6,
		CMD_EQUAL = 3'd7
	} cmd_t;

	typedef logic signed [ElemWidth-1:0] elem_t;

	// one saturated element and its overflow mark
	typedef struct packed {
		elem_t value;
		logic ovf;
	} sat_t;

	function automatic sat_t sat_wide(input logic signed [SumWidth+1:0] v);
		sat_t r;
		logic signed [SumWidth+1:0] hi;
		logic signed [SumWidth+1:0] lo;
		hi = (SumWidth+2)'((64'sd1 <<< (ElemWidth - 1)) - 64'sd1);
		lo = -hi - (SumWidth+2)'(1);
		r.ovf = 1'b0;
		r.value = elem_t'(v);
		if (v > hi) begin
			r.value = elem_t'(hi);
			r.ovf = 1'b1;
		end else if (v < lo) begin
			r.value = elem_t'(lo);
			r.ovf = 1'b1;
		end
		return r;
	endfunction

endpackage

// ===== design/m2alu_divider.sv =====
// pipelined radix-2 restoring divider, one quotient bit per stage
module m2alu_divider
	import m2alu_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic [NumWidth-1:0] num,
	input  logic [DetWidth-1:0] den,
	input  logic                neg,
	input  logic                in_valid,
	output logic [QuoWidth-1:0] quo,
	output logic                out_neg,
	output logic                out_valid
);

	logic [DetWidth-1:0] rem_s [QuoWidth+1];
	logic [NumWidth-1:0] num_s [QuoWidth+1];
	logic [QuoWidth-1:0] quo_s [QuoWidth+1];
	logic [DetWidth-1:0] den_s [QuoWidth+1];
	logic neg_s [QuoWidth+1];
	logic vld_s [QuoWidth+1];

	assign rem_s[0] = '0;
	assign num_s[0] = num;
	assign quo_s[0] = '0;
	assign den_s[0] = den;
	assign neg_s[0] = neg;
	assign vld_s[0] = in_valid;

	for (genvar k = 0; k < QuoWidth; k++) begin : g_step
		logic [DetWidth:0] trial;
		logic [DetWidth:0] diff;
		assign trial = {rem_s[k], num_s[k][NumWidth-1]};
		assign diff = trial - {1'b0, den_s[k]};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (!diff[DetWidth]) begin
					rem_s[k+1] <= diff[DetWidth-1:0];
				end else begin
					rem_s[k+1] <= trial[DetWidth-1:0];
				end
				quo_s[k+1] <= {quo_s[k][QuoWidth-2:0], ~diff[DetWidth]};
				num_s[k+1] <= {num_s[k][NumWidth-2:0], 1'b0};
				den_s[k+1] <= den_s[k];
				neg_s[k+1] <= neg_s[k];
			end
		end
	end

	assign quo = quo_s[QuoWidth];
	assign out_neg = neg_s[QuoWidth];
	assign out_valid = vld_s[QuoWidth];

endmodule

// ===== design/matrix2x2_alu.sv =====
// top level of the pipelined 2x2 matrix arithmetic unit
// Fully pipelined 2x2 Q8.8 matrix unit: one word is accepted every cycle while the
// output is taken, and the pipeline has 37 register stages (stage 1 products, stage 2
// sums and determinant, stage 3 divider setup, 33 radix-2 divider stages that carry
// every command, then saturation and the output register). The whole pipeline advances
// together and holds when the output word is not taken, so a stall loses nothing and
// throughput is one word per cycle.
module matrix2x2_alu
	import m2alu_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// command[2:0], left_e00..left_e11, right_e00..right_e11, scale_factor
	input  logic [151:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// res_e00, res_e01, res_e10, res_e11, is_equal, overflow, singular
	output logic [71:0]  m_tdata
);

	logic en;
	assign en = !m_tvalid || m_tready;
	assign s_tready = en;

	cmd_t cmd_in;
	elem_t l_in [4];
	elem_t r_in [4];
	elem_t s_in;
	assign cmd_in = cmd_t'(s_tdata[2:0]);
	for (genvar i = 0; i < 4; i++) begin : g_unp
		assign l_in[i] = s_tdata[3+16*i +: 16];
		assign r_in[i] = s_tdata[67+16*i +: 16];
	end
	assign s_in = s_tdata[131 +: 16];

	// stage 1: products and element sums
	logic vld_s1;
	cmd_t cmd_s1;
	logic signed [ProdWidth-1:0] p_s1 [8];
	logic signed [ProdWidth-1:0] dp_s1 [2];
	logic signed [ElemWidth:0] as_s1 [4];
	elem_t l_s1 [4];
	logic eq_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1 <= cmd_in;
			l_s1 <= l_in;
			eq_s1 <= (l_in[0] == r_in[0]) && (l_in[1] == r_in[1])
				&& (l_in[2] == r_in[2]) && (l_in[3] == r_in[3]);
			dp_s1[0] <= l_in[0] * l_in[3];
			dp_s1[1] <= l_in[1] * l_in[2];
			for (int i = 0; i < 4; i++) begin
				if (cmd_in == CMD_SUB) begin
					as_s1[i] <= (ElemWidth+1)'(l_in[i]) - (ElemWidth+1)'(r_in[i]);
				end else begin
					as_s1[i] <= (ElemWidth+1)'(l_in[i]) + (ElemWidth+1)'(r_in[i]);
				end
			end
			if (cmd_in == CMD_SCALE) begin
				for (int i = 0; i < 4; i++) begin
					p_s1[i] <= l_in[i] * s_in;
					p_s1[4+i] <= '0;
				end
			end else begin
				p_s1[0] <= l_in[0] * r_in[0];
				p_s1[1] <= l_in[0] * r_in[1];
				p_s1[2] <= l_in[2] * r_in[0];
				p_s1[3] <= l_in[2] * r_in[1];
				p_s1[4] <= l_in[1] * r_in[2];
				p_s1[5] <= l_in[1] * r_in[3];
				p_s1[6] <= l_in[3] * r_in[2];
				p_s1[7] <= l_in[3] * r_in[3];
			end
		end
	end

	// stage 2: pre-shift values and determinant
	logic vld_s2;
	cmd_t cmd_s2;
	logic signed [SumWidth-1:0] w_s2 [4];
	logic signed [DetWidth-1:0] det_s2;
	elem_t l_s2 [4];
	logic eq_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s2 <= cmd_s1;
			l_s2 <= l_s1;
			eq_s2 <= eq_s1;
			det_s2 <= DetWidth'(dp_s1[0]) - DetWidth'(dp_s1[1]);
			for (int i = 0; i < 4; i++) begin
				case (cmd_s1)
					CMD_ADD, CMD_SUB: w_s2[i] <= SumWidth'(as_s1[i]) <<< FracBits;
					// transpose swaps the two off-diagonal elements
					CMD_TRANSPOSE: w_s2[i] <= SumWidth'(l_s1[{i[0], i[1]}]) <<< FracBits;
					CMD_DET: begin
						if (i == 0) begin
							w_s2[i] <= SumWidth'(dp_s1[0]) - SumWidth'(dp_s1[1]);
						end else begin
							w_s2[i] <= '0;
						end
					end
					default: w_s2[i] <= SumWidth'(p_s1[i]) + SumWidth'(p_s1[4+i]);
				endcase
			end
		end
	end

	// stage 3: divider operands, magnitudes and signs
	logic vld_s3;
	cmd_t cmd_s3;
	logic signed [SumWidth-1:0] w_s3 [4];
	logic [NumWidth-1:0] num_s3 [4];
	logic [DetWidth-1:0] den_s3;
	logic neg_s3 [4];
	logic eq_s3;
	logic sing_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		logic signed [ElemWidth:0] adj [4];
		logic [ElemWidth:0] mag;
		if (en) begin
			adj[0] = (ElemWidth+1)'(l_s2[3]);
			adj[1] = -(ElemWidth+1)'(l_s2[1]);
			adj[2] = -(ElemWidth+1)'(l_s2[2]);
			adj[3] = (ElemWidth+1)'(l_s2[0]);
			cmd_s3 <= cmd_s2;
			w_s3 <= w_s2;
			eq_s3 <= eq_s2;
			sing_s3 <= (det_s2 == '0);
			den_s3 <= det_s2[DetWidth-1] ? DetWidth'(-det_s2) : DetWidth'(det_s2);
			for (int i = 0; i < 4; i++) begin
				mag = adj[i][ElemWidth] ? -adj[i] : adj[i];
				num_s3[i] <= {mag, {(2*FracBits){1'b0}}};
				neg_s3[i] <= adj[i][ElemWidth] != det_s2[DetWidth-1];
			end
		end
	end

	// divider lanes with a side delay line carrying the other results
	localparam int DivDepth = QuoWidth;
	logic [QuoWidth-1:0] q_d [4];
	logic qneg_d [4];
	logic qv_d [4];

	for (genvar i = 0; i < 4; i++) begin : g_div
		m2alu_divider u_div (
			.clk(clk), .arst_n(arst_n), .en(en),
			.num(num_s3[i]), .den(den_s3), .neg(neg_s3[i]), .in_valid(vld_s3),
			.quo(q_d[i]), .out_neg(qneg_d[i]), .out_valid(qv_d[i])
		);
	end

	cmd_t cmd_d [DivDepth+1];
	logic signed [SumWidth-1:0] w_d [DivDepth+1][4];
	logic eq_d [DivDepth+1];
	logic sing_d [DivDepth+1];
	assign cmd_d[0] = cmd_s3;
	assign w_d[0] = w_s3;
	assign eq_d[0] = eq_s3;
	assign sing_d[0] = sing_s3;
	for (genvar k = 0; k < DivDepth; k++) begin : g_dly
		always_ff @(posedge clk) begin
			if (en) begin
				cmd_d[k+1] <= cmd_d[k];
				w_d[k+1] <= w_d[k];
				eq_d[k+1] <= eq_d[k];
				sing_d[k+1] <= sing_d[k];
			end
		end
	end

	// final stage: shift, saturate, register
	logic [71:0] out_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= qv_d[0];
		end
	end

	always_ff @(posedge clk) begin
		sat_t r [4];
		logic ov;
		logic [QuoWidth-1:0] lim;
		logic [QuoWidth-1:0] q;
		if (en) begin
			ov = 1'b0;
			for (int i = 0; i < 4; i++) begin
				r[i] = sat_wide((SumWidth+2)'(w_d[DivDepth][i] >>> FracBits));
				if (cmd_d[DivDepth] == CMD_INVERSE) begin
					q = q_d[i];
					lim = QuoWidth'(1) << (ElemWidth - 1);
					if (qneg_d[i]) begin
						if (q > lim) begin
							q = lim;
							r[i].ovf = 1'b1;
						end else begin
							r[i].ovf = 1'b0;
						end
						r[i].value = elem_t'(-q);
					end else begin
						if (q > lim - 1'b1) begin
							q = lim - 1'b1;
							r[i].ovf = 1'b1;
						end else begin
							r[i].ovf = 1'b0;
						end
						r[i].value = elem_t'(q);
					end
					if (sing_d[DivDepth]) begin
						r[i] = '0;
					end
				end else if (cmd_d[DivDepth] == CMD_EQUAL) begin
					r[i] = '0;
				end
				ov = ov | r[i].ovf;
			end
			out_q <= {5'b00000,
				(cmd_d[DivDepth] == CMD_INVERSE) && sing_d[DivDepth],
				ov,
				(cmd_d[DivDepth] == CMD_EQUAL) && eq_d[DivDepth],
				r[3].value, r[2].value, r[1].value, r[0].value};
		end
	end

	assign m_tdata = out_q;

endmodule
